[rtl/bpa_pkg.sv]
// Shared constants, codes and helper functions for the buddy page allocator.
// No dependencies; used by the allocator core and its port checker.
`default_nettype none
package bpa_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int NUM_ORDERS = 13;
  localparam int PG_W       = 12;  // page index
  localparam int LNK_W      = 13;  // page index or "none"
  localparam int PRV_W      = 14;  // page index or list-top marker
  localparam int ORD_W      = 4;
  localparam int ROW_BITS   = 32;  // bitmap bits per memory row
  localparam int ROW_SH     = 5;
  localparam int ROW_W      = PG_W - ROW_SH;
  localparam int NUM_ROWS   = NUM_PAGES / ROW_BITS;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  localparam logic CFG_POOL_START = 1'b0;
  localparam logic CFG_POOL_PAGES = 1'b1;

  localparam logic [LNK_W-1:0] LNK_NONE = LNK_W'(NUM_PAGES);

  // Bits of one bitmap row that fall in [lo, hi).
  function automatic logic [ROW_BITS-1:0] range_mask(input logic [ROW_W-1:0] row,
                                                     input logic [LNK_W-1:0] lo,
                                                     input logic [LNK_W-1:0] hi);
    logic [ROW_BITS-1:0] m;
    logic [LNK_W-1:0]    idx;
    for (int k = 0; k < ROW_BITS; k++) begin
      idx  = {1'b0, row, ROW_SH'(k)};
      m[k] = (idx >= lo) && (idx < hi);
    end
    return m;
  endfunction

  // End of a chunk of 2^ord pages from lo, clipped to the page count.
  function automatic logic [LNK_W-1:0] chunk_end(input logic [PG_W-1:0] lo,
                                                 input logic [ORD_W-1:0] ord);
    logic [LNK_W:0] s;
    s = {2'b0, lo} + ((LNK_W+1)'(1) << ord);
    if (s > (LNK_W+1)'(NUM_PAGES)) begin
      s = (LNK_W+1)'(NUM_PAGES);
    end
    return s[LNK_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/buddy_page_allocator_core.sv]
// Buddy page allocator core: bitmap, free lists and order tags in on-chip memories.
// Depends on bpa_pkg.
`default_nettype none
// Init clears the bitmap and carves the pool into chunks; alloc splits a chunk down
// order by order, then marks its 32-page bitmap rows; free clears the chunk's rows,
// then merges buddies. One request at a time; busy stays high until the result.
// The result strobe out_valid lasts one cycle and cannot be stalled.
// Reset: synchronous; a clearing pass over every bitmap row marks every page used,
// busy is high during it. Bitmap sweeps and list walks use one memory port each.
module buddy_page_allocator_core (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  output logic                      busy,
  input  wire  [1:0]                in_op,
  input  wire  [3:0]                in_order,
  input  wire  [11:0]               in_page,
  output logic                      out_valid,
  output logic [11:0]               out_page_out,
  output logic [1:0]                out_status,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire                       cfg_index,
  input  wire  [12:0]               cfg_data
);

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_CARVE  = 14'b00000000000100,
    S_PUSH_A = 14'b00000000001000,
    S_PUSH_B = 14'b00000000010000,
    S_UNL_RD = 14'b00000000100000,
    S_UNL_WR = 14'b00000001000000,
    S_SPLIT  = 14'b00000010000000,
    S_MARK_RD= 14'b00000100000000,
    S_MARK_WR= 14'b00001000000000,
    S_FR_BUD = 14'b00010000000000,
    S_FR_RD  = 14'b00100000000000,
    S_FR_CHK = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t state_r;

  // Configuration
  logic [bpa_pkg::PG_W-1:0]  pstart_r;
  logic [bpa_pkg::LNK_W-1:0] ppages_r;

  // Memories: bitmap rows, order tags, forward and backward links
  logic [bpa_pkg::ROW_BITS-1:0] used_mem [bpa_pkg::NUM_ROWS];
  logic [bpa_pkg::ORD_W-1:0]    head_mem [bpa_pkg::NUM_PAGES];
  logic [bpa_pkg::LNK_W-1:0]    next_mem [bpa_pkg::NUM_PAGES];
  logic [bpa_pkg::PRV_W-1:0]    prev_mem [bpa_pkg::NUM_PAGES];

  logic [bpa_pkg::ROW_BITS-1:0] used_rd;
  logic [bpa_pkg::ORD_W-1:0]    head_rd;
  logic [bpa_pkg::LNK_W-1:0]    next_rd;
  logic [bpa_pkg::PRV_W-1:0]    prev_rd;

  logic                         used_we;
  logic [bpa_pkg::ROW_W-1:0]    used_waddr, used_raddr;
  logic [bpa_pkg::ROW_BITS-1:0] used_wdata;
  logic                         head_we, next_we, prev_we;
  logic [bpa_pkg::PG_W-1:0]     head_waddr, next_waddr, prev_waddr;
  logic [bpa_pkg::ORD_W-1:0]    head_wdata;
  logic [bpa_pkg::LNK_W-1:0]    next_wdata;
  logic [bpa_pkg::PRV_W-1:0]    prev_wdata;

  // List tops
  logic [bpa_pkg::LNK_W-1:0] top_r [bpa_pkg::NUM_ORDERS];

  // Working registers
  logic [bpa_pkg::LNK_W-1:0] cs_r, cr_r;        // carve cursor and remaining pages
  logic                      init_r;            // sweep continues into carving
  logic [bpa_pkg::ROW_W-1:0] mrow_r, mlast_r;   // bitmap row walk
  logic [bpa_pkg::LNK_W-1:0] mlo_r, mhi_r;
  logic                      mset_r;
  logic [1:0]                op_r;
  logic [bpa_pkg::ORD_W-1:0] ord_r, ai_r, fo_r, po_r;
  logic [bpa_pkg::PG_W-1:0]  ch_r, la_r, fp_r, bud_r, pp_r;
  logic [bpa_pkg::LNK_W-1:0] pt_r;
  logic [bpa_pkg::PG_W-1:0]  rpage_r;
  logic [1:0]                rstat_r;
  logic                      out_valid_r;
  logic [bpa_pkg::PG_W-1:0]  out_page_r;
  logic [1:0]                out_status_r;

  // Combinational helpers
  logic [bpa_pkg::ROW_BITS-1:0] sweep_mask, mark_mask;
  logic [bpa_pkg::LNK_W-1:0]    avail, push_t;
  logic [bpa_pkg::ORD_W-1:0]    carve_ord, fnd_ord;
  logic                         fnd, carve_ok;
  logic [bpa_pkg::LNK_W-1:0]    unl_n;
  logic [bpa_pkg::PRV_W-1:0]    unl_q, unl_qo;
  logic [bpa_pkg::ORD_W-1:0]    split_ord;
  logic [bpa_pkg::LNK_W-1:0]    split_pg;
  logic [bpa_pkg::PG_W-1:0]     bud_pg;
  logic [bpa_pkg::LNK_W-1:0]    in_end, ch_end;

  assign busy         = (state_r != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_page_out = out_page_r;
  assign out_status   = out_status_r;

  assign sweep_mask = bpa_pkg::range_mask(mrow_r, cs_r, cs_r + cr_r);
  assign mark_mask  = bpa_pkg::range_mask(mrow_r, mlo_r, mhi_r);
  assign avail      = bpa_pkg::LNK_W'(bpa_pkg::NUM_PAGES) - {1'b0, pstart_r};
  assign push_t     = top_r[po_r];
  assign unl_n      = next_rd;
  assign unl_q      = prev_rd;
  assign unl_qo     = unl_q - bpa_pkg::PRV_W'(bpa_pkg::NUM_PAGES);
  assign split_ord  = ai_r - 1'b1;
  assign split_pg   = {1'b0, ch_r} + (bpa_pkg::LNK_W'(1) << split_ord);
  assign bud_pg     = fp_r ^ (bpa_pkg::PG_W'(1) << fo_r);
  assign in_end     = bpa_pkg::chunk_end(in_page, in_order);
  assign ch_end     = bpa_pkg::chunk_end(ch_r, ord_r);

  // Largest aligned chunk that fits at the carve cursor.
  always_comb begin
    carve_ord = '0;
    carve_ok  = 1'b1;
    for (int k = 1; k < bpa_pkg::NUM_ORDERS; k++) begin
      carve_ok = carve_ok && ((bpa_pkg::LNK_W'(1) << k) <= cr_r) && !cs_r[k-1];
      if (carve_ok) begin
        carve_ord = bpa_pkg::ORD_W'(k);
      end
    end
  end

  // Smallest non-empty list at or above the requested order.
  always_comb begin
    fnd     = 1'b0;
    fnd_ord = '0;
    for (int k = bpa_pkg::NUM_ORDERS - 1; k >= 0; k--) begin
      if ((bpa_pkg::ORD_W'(k) >= in_order) && (top_r[k] != bpa_pkg::LNK_NONE)) begin
        fnd     = 1'b1;
        fnd_ord = bpa_pkg::ORD_W'(k);
      end
    end
  end

  // Memory port control, decoded from the current step
  always_comb begin
    used_we    = 1'b0;
    used_waddr = mrow_r;
    used_wdata = '0;
    used_raddr = mrow_r;
    head_we    = 1'b0;
    head_waddr = pp_r;
    head_wdata = po_r;
    next_we    = 1'b0;
    next_waddr = pp_r;
    next_wdata = push_t;
    prev_we    = 1'b0;
    prev_waddr = pp_r;
    prev_wdata = bpa_pkg::PRV_W'(bpa_pkg::NUM_PAGES) + bpa_pkg::PRV_W'(po_r);
    case (state_r)
      S_CLEAR: begin
        used_we    = 1'b1;
        used_wdata = ~sweep_mask;
      end
      S_MARK_WR: begin
        used_we    = 1'b1;
        used_wdata = mset_r ? (used_rd | mark_mask) : (used_rd & ~mark_mask);
      end
      S_FR_RD: begin
        used_raddr = bud_r[bpa_pkg::PG_W-1:bpa_pkg::ROW_SH];
      end
      S_PUSH_A: begin
        head_we = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      S_PUSH_B: begin
        prev_we    = 1'b1;
        prev_waddr = pt_r[bpa_pkg::PG_W-1:0];
        prev_wdata = {2'b0, pp_r};
      end
      S_UNL_WR: begin
        // Bypass the chunk: predecessor points past it, successor points back.
        next_we    = (unl_q < bpa_pkg::PRV_W'(bpa_pkg::NUM_PAGES));
        next_waddr = unl_q[bpa_pkg::PG_W-1:0];
        next_wdata = unl_n;
        prev_we    = (unl_n < bpa_pkg::LNK_NONE);
        prev_waddr = unl_n[bpa_pkg::PG_W-1:0];
        prev_wdata = unl_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_waddr] <= used_wdata;
    end
    used_rd <= used_mem[used_raddr];
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd <= head_mem[la_r];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd <= next_mem[la_r];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    prev_rd <= prev_mem[la_r];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstart_r <= '0;
      ppages_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpa_pkg::CFG_POOL_START: pstart_r <= cfg_data[bpa_pkg::PG_W-1:0];
        bpa_pkg::CFG_POOL_PAGES: ppages_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Result register: one-cycle strobe after the final step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_DONE);
    end
    if (state_r == S_DONE) begin
      out_page_r   <= rpage_r;
      out_status_r <= rstat_r;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      mrow_r  <= '0;
      cs_r    <= '0;
      cr_r    <= '0;
      init_r  <= 1'b0;
      for (int k = 0; k < bpa_pkg::NUM_ORDERS; k++) begin
        top_r[k] <= bpa_pkg::LNK_NONE;
      end
    end else begin
      case (state_r)
        S_CLEAR: begin
          // Rewrite each bitmap row: pool pages free, all others used.
          mrow_r <= mrow_r + 1'b1;
          if (mrow_r == bpa_pkg::ROW_W'(bpa_pkg::NUM_ROWS - 1)) begin
            init_r  <= 1'b0;
            state_r <= init_r ? S_CARVE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r    <= in_op;
            rpage_r <= '0;
            rstat_r <= bpa_pkg::ST_OK;
            case (in_op)
              bpa_pkg::OP_INIT: begin
                cs_r    <= {1'b0, pstart_r};
                cr_r    <= (ppages_r > avail) ? avail : ppages_r;
                mrow_r  <= '0;
                init_r  <= 1'b1;
                for (int k = 0; k < bpa_pkg::NUM_ORDERS; k++) begin
                  top_r[k] <= bpa_pkg::LNK_NONE;
                end
                state_r <= S_CLEAR;
              end
              bpa_pkg::OP_ALLOC: begin
                ord_r <= in_order;
                if (in_order >= bpa_pkg::ORD_W'(bpa_pkg::NUM_ORDERS)) begin
                  rstat_r <= bpa_pkg::ST_ORDER;
                  state_r <= S_DONE;
                end else if (!fnd) begin
                  rstat_r <= bpa_pkg::ST_NOMEM;
                  state_r <= S_DONE;
                end else begin
                  ch_r    <= top_r[fnd_ord][bpa_pkg::PG_W-1:0];
                  la_r    <= top_r[fnd_ord][bpa_pkg::PG_W-1:0];
                  ai_r    <= fnd_ord;
                  state_r <= S_UNL_RD;
                end
              end
              bpa_pkg::OP_FREE: begin
                if (in_order >= bpa_pkg::ORD_W'(bpa_pkg::NUM_ORDERS)) begin
                  rstat_r <= bpa_pkg::ST_ORDER;
                  state_r <= S_DONE;
                end else begin
                  fp_r    <= in_page;
                  fo_r    <= in_order;
                  mlo_r   <= {1'b0, in_page};
                  mhi_r   <= in_end;
                  mrow_r  <= in_page[bpa_pkg::PG_W-1:bpa_pkg::ROW_SH];
                  mlast_r <= bpa_pkg::ROW_W'((in_end - 1'b1) >> bpa_pkg::ROW_SH);
                  mset_r  <= 1'b0;
                  state_r <= S_MARK_RD;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_CARVE: begin
          if (cr_r == '0) begin
            state_r <= S_DONE;
          end else begin
            pp_r    <= cs_r[bpa_pkg::PG_W-1:0];
            po_r    <= carve_ord;
            cs_r    <= cs_r + (bpa_pkg::LNK_W'(1) << carve_ord);
            cr_r    <= cr_r - (bpa_pkg::LNK_W'(1) << carve_ord);
            state_r <= S_PUSH_A;
          end
        end
        S_PUSH_A: begin
          // Head of list: link the new chunk in front of the old top.
          top_r[po_r] <= {1'b0, pp_r};
          pt_r        <= push_t;
          if (push_t != bpa_pkg::LNK_NONE) begin
            state_r <= S_PUSH_B;
          end else if (op_r == bpa_pkg::OP_INIT) begin
            state_r <= S_CARVE;
          end else if (op_r == bpa_pkg::OP_ALLOC) begin
            state_r <= S_SPLIT;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_PUSH_B: begin
          if (op_r == bpa_pkg::OP_INIT) begin
            state_r <= S_CARVE;
          end else if (op_r == bpa_pkg::OP_ALLOC) begin
            state_r <= S_SPLIT;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_UNL_RD: begin
          // Wait for the link read.
          state_r <= S_UNL_WR;
        end
        S_UNL_WR: begin
          if ((unl_q >= bpa_pkg::PRV_W'(bpa_pkg::NUM_PAGES)) &&
              (unl_qo < bpa_pkg::PRV_W'(bpa_pkg::NUM_ORDERS))) begin
            top_r[unl_qo[bpa_pkg::ORD_W-1:0]] <= unl_n;
          end
          if (op_r == bpa_pkg::OP_ALLOC) begin
            state_r <= S_SPLIT;
          end else begin
            // Merged with the buddy: the pair starts at the lower half.
            fp_r    <= fp_r & ~(bpa_pkg::PG_W'(1) << fo_r);
            fo_r    <= fo_r + 1'b1;
            state_r <= S_FR_BUD;
          end
        end
        S_SPLIT: begin
          if (ai_r == ord_r) begin
            mlo_r   <= {1'b0, ch_r};
            mhi_r   <= ch_end;
            mrow_r  <= ch_r[bpa_pkg::PG_W-1:bpa_pkg::ROW_SH];
            mlast_r <= bpa_pkg::ROW_W'((ch_end - 1'b1) >> bpa_pkg::ROW_SH);
            mset_r  <= 1'b1;
            state_r <= S_MARK_RD;
          end else begin
            // Drop one order; return the upper half to its list.
            ai_r <= split_ord;
            if (split_pg < bpa_pkg::LNK_NONE) begin
              pp_r    <= split_pg[bpa_pkg::PG_W-1:0];
              po_r    <= split_ord;
              state_r <= S_PUSH_A;
            end
          end
        end
        S_MARK_RD: begin
          state_r <= S_MARK_WR;
        end
        S_MARK_WR: begin
          if (mrow_r == mlast_r) begin
            if (op_r == bpa_pkg::OP_ALLOC) begin
              rpage_r <= ch_r;
              state_r <= S_DONE;
            end else begin
              state_r <= S_FR_BUD;
            end
          end else begin
            mrow_r  <= mrow_r + 1'b1;
            state_r <= S_MARK_RD;
          end
        end
        S_FR_BUD: begin
          if (fo_r >= bpa_pkg::ORD_W'(bpa_pkg::NUM_ORDERS - 1)) begin
            pp_r    <= fp_r;
            po_r    <= fo_r;
            state_r <= S_PUSH_A;
          end else begin
            bud_r   <= bud_pg;
            la_r    <= bud_pg;
            state_r <= S_FR_RD;
          end
        end
        S_FR_RD: begin
          state_r <= S_FR_CHK;
        end
        S_FR_CHK: begin
          // Merge only with a free buddy that heads a chunk of this order.
          if (used_rd[bud_r[bpa_pkg::ROW_SH-1:0]] || (head_rd != fo_r)) begin
            pp_r    <= fp_r;
            po_r    <= fo_r;
            state_r <= S_PUSH_A;
          end else begin
            state_r <= S_UNL_WR;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/bpa_port_checker.sv]
// Port-level checks for the buddy page allocator core, bound to the allocator core.
// Depends on bpa_pkg and buddy_page_allocator_core.
`default_nettype none
module bpa_port_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        out_valid,
  input wire [11:0] out_page_out,
  input wire [1:0]  out_status
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == bpa_pkg::ST_OK || out_status == bpa_pkg::ST_NOMEM ||
                   out_status == bpa_pkg::ST_ORDER))
    else $error("unknown status code");

  a_fail_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bpa_pkg::ST_OK) |-> (out_page_out == 12'd0))
    else $error("failed request returned a page");

endmodule

bind buddy_page_allocator_core bpa_port_checker u_bpa_port_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_page_out (out_page_out),
  .out_status   (out_status)
);
`default_nettype wire
